### rtl/ldsol_pkg.sv
// Shared widths, status codes, beat payload types and helpers for the linear Diophantine solver.
package ldsol_pkg;

    localparam int DATA_WIDTH = 32;
    // Bezout coefficients stay within the data range plus sign; two guard bits keep them exact.
    localparam int COEF_W = DATA_WIDTH + 2;
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int CNT_W  = $clog2(DATA_WIDTH);

    localparam logic [1:0] ST_SOLVED = 2'd0;
    localparam logic [1:0] ST_NO_SOL = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] coef_a;
        logic signed [DATA_WIDTH-1:0] coef_b;
        logic signed [DATA_WIDTH-1:0] rhs;
    } item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sol_x;
        logic signed [DATA_WIDTH-1:0] sol_y;
        logic [1:0]                   status;
        logic                         overflow;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_step;
        logic       rotate;
        logic       fdiv_start;
        logic       mul_start;
        logic       mul_step;
        logic       capture;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic both_zero;
        logic r0_zero;
        logic rem_nz;
    } sts_t;

    function automatic logic [DATA_WIDTH-1:0] mag_data(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] mag_coef(input logic [COEF_W-1:0] v);
        logic [COEF_W-1:0] m;
        m = v[COEF_W-1] ? (~v + 1'b1) : v;
        return m[DATA_WIDTH-1:0];
    endfunction

endpackage

### rtl/ldsol_ctrl.sv
// Sequencer for the solver: Euclid steps, final division, scaling multiply and result hand-off.
module ldsol_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  logic          result_stall,
    input  ldsol_pkg::sts_t sts,
    output ldsol_pkg::cmd_t cmd
);
    import ldsol_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_STEP  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_ROT   = 4'd4;
    localparam logic [3:0] S_FDIV  = 4'd5;
    localparam logic [3:0] S_FCHK  = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       status_reg, status_next;
    logic             valid_reg, valid_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        valid_next  = valid_reg && result_stall;
        cmd         = '0;
        cmd.status  = status_reg;
        item_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.both_zero)
                begin
                    status_next = ST_ZERO;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cnt_next = '0;
                if (sts.r0_zero)
                begin
                    cmd.fdiv_start = 1'b1;
                    state_next     = S_FDIV;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.rotate = 1'b1;
                state_next = S_STEP;
            end
            S_FDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                cnt_next = '0;
                if (sts.rem_nz)
                begin
                    status_next = ST_NO_SOL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    status_next = ST_SOLVED;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!valid_reg || !result_stall)
                begin
                    cmd.capture = 1'b1;
                    valid_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            status_reg <= ST_SOLVED;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            valid_reg  <= valid_next;
        end
    end

    assign result_valid = valid_reg;

`ifndef ASSERT_OFF
    // A new result must never overwrite one that is still waiting to be taken.
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!valid_reg || !result_stall))
        else $error("result captured while previous beat still pending");

    // An accepted beat always starts the zero-coefficient check.
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_CHECK))
        else $error("accepted beat did not start processing");

    // Every division or multiply pass starts from a cleared bit counter.
    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP || state_reg == S_FCHK) |=> (cnt_reg == '0))
        else $error("bit counter not cleared before a pass");
`endif

endmodule

### rtl/ldsol_dpath.sv
// Datapath for the solver: restoring divider, Bezout row accumulators and serial scaling multiplier.
module ldsol_dpath (
    input  logic               clk,
    input  ldsol_pkg::cmd_t    cmd,
    input  ldsol_pkg::item_t   item,
    output ldsol_pkg::sts_t    sts,
    output ldsol_pkg::result_t result
);
    import ldsol_pkg::*;

    logic                     a_neg_reg, b_neg_reg, c_neg_reg;
    logic [DATA_WIDTH-1:0]    mc_reg;
    logic [DATA_WIDTH-1:0]    r0_reg, r1_reg;
    logic signed [COEF_W-1:0] sx_reg, tx_reg, sy_reg, ty_reg;
    logic signed [COEF_W-1:0] accx_reg, accy_reg;
    logic [DATA_WIDTH-1:0]    num_reg, den_reg, rem_reg, quo_reg;
    logic [DATA_WIDTH-1:0]    mx_reg, my_reg;
    logic                     negx_reg, negy_reg;
    logic [PROD_W-1:0]        px_reg, py_reg;
    result_t                  result_reg;

    logic [DATA_WIDTH:0]      trial;
    logic                     ge;
    logic [DATA_WIDTH:0]      diff;
    logic [PROD_W-1:0]        lim_x, lim_y;
    logic [DATA_WIDTH-1:0]    sol_x_mag, sol_y_mag;

    // One restoring division step: the quotient bit is final as soon as it is formed.
    assign trial = {rem_reg, num_reg[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    assign lim_x = (PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(!negx_reg);
    assign lim_y = (PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(!negy_reg);
    assign sol_x_mag = px_reg[DATA_WIDTH-1:0];
    assign sol_y_mag = py_reg[DATA_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_neg_reg <= item.coef_a[DATA_WIDTH-1];
            b_neg_reg <= item.coef_b[DATA_WIDTH-1];
            c_neg_reg <= item.rhs[DATA_WIDTH-1];
            mc_reg    <= mag_data(item.rhs);
            r0_reg    <= mag_data(item.coef_a);
            r1_reg    <= mag_data(item.coef_b);
            sx_reg    <= COEF_W'(1);
            tx_reg    <= '0;
            sy_reg    <= '0;
            ty_reg    <= COEF_W'(1);
        end
        if (cmd.div_start)
        begin
            num_reg  <= r1_reg;
            den_reg  <= r0_reg;
            rem_reg  <= '0;
            accx_reg <= '0;
            accy_reg <= '0;
        end
        if (cmd.fdiv_start)
        begin
            num_reg <= mc_reg;
            den_reg <= r1_reg;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            num_reg  <= {num_reg[DATA_WIDTH-2:0], 1'b0};
            quo_reg  <= {quo_reg[DATA_WIDTH-2:0], ge};
            accx_reg <= (accx_reg <<< 1) + (ge ? sx_reg : '0);
            accy_reg <= (accy_reg <<< 1) + (ge ? sy_reg : '0);
        end
        if (cmd.rotate)
        begin
            r1_reg <= r0_reg;
            r0_reg <= rem_reg;
            sx_reg <= tx_reg - accx_reg;
            tx_reg <= sx_reg;
            sy_reg <= ty_reg - accy_reg;
            ty_reg <= sy_reg;
        end
        if (cmd.mul_start)
        begin
            mx_reg   <= mag_coef(tx_reg);
            my_reg   <= mag_coef(ty_reg);
            negx_reg <= tx_reg[COEF_W-1] ^ c_neg_reg ^ a_neg_reg;
            negy_reg <= ty_reg[COEF_W-1] ^ c_neg_reg ^ b_neg_reg;
            px_reg   <= '0;
            py_reg   <= '0;
        end
        if (cmd.mul_step)
        begin
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b0};
            px_reg  <= (px_reg << 1)
                       + (quo_reg[DATA_WIDTH-1] ? PROD_W'(mx_reg) : '0);
            py_reg  <= (py_reg << 1)
                       + (quo_reg[DATA_WIDTH-1] ? PROD_W'(my_reg) : '0);
        end
        if (cmd.capture)
        begin
            result_reg.status <= cmd.status;
            if (cmd.status == ST_SOLVED)
            begin
                result_reg.sol_x    <= negx_reg ? (~sol_x_mag + 1'b1) : sol_x_mag;
                result_reg.sol_y    <= negy_reg ? (~sol_y_mag + 1'b1) : sol_y_mag;
                result_reg.overflow <= (px_reg > lim_x) || (py_reg > lim_y);
            end
            else
            begin
                result_reg.sol_x    <= '0;
                result_reg.sol_y    <= '0;
                result_reg.overflow <= 1'b0;
            end
        end
    end

    assign sts.both_zero = (r0_reg == '0) && (r1_reg == '0);
    assign sts.r0_zero   = (r0_reg == '0);
    assign sts.rem_nz    = (rem_reg != '0);
    assign result        = result_reg;

`ifndef ASSERT_OFF
    // A Euclid step must leave a remainder strictly below its divisor.
    a_rem_below: assert property (@(posedge clk)
        cmd.rotate |-> (rem_reg < den_reg))
        else $error("division remainder not below divisor");

    // Loading an item seeds the Bezout rows with the identity.
    a_load_ident: assert property (@(posedge clk)
        cmd.load |=> (sx_reg == COEF_W'(1) && ty_reg == COEF_W'(1)
                      && tx_reg == '0 && sy_reg == '0))
        else $error("Bezout rows not seeded with identity");

    // The divider never runs against a zero divisor.
    a_den_nonzero: assert property (@(posedge clk)
        cmd.div_step |-> (den_reg != '0))
        else $error("division step with zero divisor");
`endif

endmodule

### rtl/linear_diophantine_solver.sv
// Top level of the linear Diophantine solver: sequencer plus datapath behind valid/stall channels.
//
// Each input beat carries signed coef_a, coef_b and rhs; the block returns one result beat with
// x and y such that coef_a*x + coef_b*y = rhs, found by the extended Euclidean algorithm on the
// coefficient magnitudes and scaled by rhs/gcd. Status reads 0 when solved, 1 when the gcd does
// not divide rhs, and 2 when both coefficients are zero; x, y and overflow are zero unless
// solved. Overflow is set when either exact product leaves the signed 32-bit range, and x and y
// then carry the wrapped low bits. One item is worked on at a time. Every Euclid step runs one
// bit-serial restoring division plus a setup and an update step, and the Bezout rows are
// accumulated during that division; the final division by the gcd and, when it leaves no
// remainder, the bit-serial scaling multiply follow the last Euclid step. The next input beat
// is taken as soon as the current result is registered, even if that result beat is still
// waiting on a stalled output.
module linear_diophantine_solver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  ldsol_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output ldsol_pkg::result_t result
);
    import ldsol_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The sequencer owns both handshakes; the datapath only follows its commands.
    ldsol_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // Divider, Bezout accumulators, scaling multiplier and the result register.
    ldsol_dpath u_dpath (
        .clk    (clk),
        .cmd    (cmd),
        .item   (item),
        .sts    (sts),
        .result (result)
    );

endmodule

### sim/tb_linear_diophantine_solver.sv
// Self-checking testbench for the linear Diophantine solver: directed table, random items, model check.
module tb_linear_diophantine_solver;

    import ldsol_pkg::*;

    // A correct run needs roughly 370 items. The limit leaves a wide margin on top of their
    // processing for stalls, idle gaps and the long output hold-off.
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          ITEMS_PER_SET = 116;
    localparam int          HOLD_CYCLES   = 4000;
    localparam int          DRAIN_CYCLES  = 2000;
    localparam int          EUCLID_DEPTH  = 128;

    // One row of the directed table. Rows with known set carry their expected result. All other
    // rows are checked against the predictor.
    typedef struct {
        item_t   stim;
        bit      known;
        result_t want;
    } dir_row_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Idle rates in percent per cycle. The main process writes them with nonblocking
    // assignments, so the other processes see a change only from the next edge on.
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    bit          hold_armed = 1'b0;

    result_t     pending_solutions[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    longint      fib[0:47];

    linear_diophantine_solver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sign-extend a data word to 64 bits so that the arithmetic below is width independent.
    function automatic bit [63:0] widen(input logic [DATA_WIDTH-1:0] v);
        bit signed [DATA_WIDTH-1:0] s;
        bit signed [63:0]           w;
        s = v;
        w = s;
        return w;
    endfunction

    // Exact signed product v*k, negated when flip is set. Bit 64 of the return value flags a
    // product outside the signed data range. The low bits carry the product wrapped to the width.
    function automatic bit [64:0] scale_bezout(input bit [63:0] v, input bit [63:0] k,
                                               input bit flip);
        bit [63:0] mv;
        bit [63:0] mk;
        bit [63:0] lim;
        bit [63:0] p;
        bit        neg;
        bit        ovf;
        mv  = v[63] ? 64'd0 - v : v;
        mk  = k[63] ? 64'd0 - k : k;
        neg = v[63] ^ k[63] ^ flip;
        lim = 64'd1 << (DATA_WIDTH - 1);
        if (!neg)
            lim = lim - 64'd1;
        ovf = (mv != 64'd0) && (mk > lim / mv);
        p   = mv * mk;
        if (neg)
            p = 64'd0 - p;
        return {ovf, p & ({64{1'b1}} >> (64 - DATA_WIDTH))};
    endfunction

    // Predicts the result beat for one item. The extended Euclidean algorithm runs on the
    // coefficient magnitudes. The quotients are kept and the Bezout pair is rebuilt backward
    // from (0, 1), then scaled by rhs/gcd with the signs of the coefficients applied.
    function automatic result_t solve_item(input item_t it);
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] c;
        bit [63:0] r0;
        bit [63:0] r1;
        bit [63:0] rem;
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] nx;
        bit [63:0] g;
        bit [63:0] mc;
        bit [63:0] kq;
        bit [63:0] k;
        bit [63:0] quo [EUCLID_DEPTH];
        bit [64:0] sx;
        bit [64:0] sy;
        int        n;
        int        i;
        result_t   res;
        a   = widen(it.coef_a);
        b   = widen(it.coef_b);
        c   = widen(it.rhs);
        r0  = a[63] ? 64'd0 - a : a;
        r1  = b[63] ? 64'd0 - b : b;
        res = '0;
        if (r0 == 64'd0 && r1 == 64'd0)
        begin
            res.status = ST_ZERO;
            return res;
        end
        n = 0;
        while (r0 != 64'd0 && n < EUCLID_DEPTH)
        begin
            rem    = r1 % r0;
            quo[n] = r1 / r0;
            n      = n + 1;
            r1     = r0;
            r0     = rem;
        end
        g = r1;
        x = 64'd0;
        y = 64'd1;
        for (i = n - 1; i >= 0; i--)
        begin
            nx = y - quo[i] * x;
            y  = x;
            x  = nx;
        end
        mc = c[63] ? 64'd0 - c : c;
        if (mc % g != 64'd0)
        begin
            res.status = ST_NO_SOL;
            return res;
        end
        kq = mc / g;
        k  = c[63] ? 64'd0 - kq : kq;
        sx = scale_bezout(x, k, a[63]);
        sy = scale_bezout(y, k, b[63]);
        res.sol_x    = sx[DATA_WIDTH-1:0];
        res.sol_y    = sy[DATA_WIDTH-1:0];
        res.status   = ST_SOLVED;
        res.overflow = sx[64] | sy[64];
        return res;
    endfunction

    function automatic item_t make_item(input longint a, input longint b, input longint c);
        item_t it;
        it.coef_a = a[DATA_WIDTH-1:0];
        it.coef_b = b[DATA_WIDTH-1:0];
        it.rhs    = c[DATA_WIDTH-1:0];
        return it;
    endfunction

    function automatic result_t make_result(input longint x, input longint y,
                                            input logic [1:0] st, input bit ovf);
        result_t r;
        r.sol_x    = x[DATA_WIDTH-1:0];
        r.sol_y    = y[DATA_WIDTH-1:0];
        r.status   = st;
        r.overflow = ovf;
        return r;
    endfunction

    // A full-width random word. The most negative value is outside the field range and is
    // moved up by one.
    function automatic longint rand_word();
        logic [31:0] v;
        v = $urandom;
        if (v == 32'h8000_0000)
            v = 32'h8000_0001;
        return longint'($signed(v));
    endfunction

    function automatic longint rand_span(input longint span);
        return longint'($urandom_range(32'(2 * span))) - span;
    endfunction

    // Random item. Most items are well formed and cheap: small coefficients, or coefficients
    // with a common factor and a right-hand side that it divides. The rest are full-width words
    // that exercise every bit and the overflow path, zero coefficients, and consecutive
    // Fibonacci pairs, which force the longest Euclid chains.
    function automatic item_t random_item();
        int unsigned pick;
        int unsigned idx;
        longint      g;
        longint      a;
        longint      b;
        longint      c;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            a = rand_span(2000);
            b = rand_span(2000);
            c = rand_span(100000);
        end
        else if (pick < 60)
        begin
            g = longint'($urandom_range(1000, 1));
            a = g * rand_span(1000);
            b = g * rand_span(1000);
            c = g * rand_span(longint'(2147483647) / g);
        end
        else if (pick < 85)
        begin
            a = rand_word();
            b = rand_word();
            c = rand_word();
        end
        else if (pick < 93)
        begin
            a = ($urandom_range(1) != 0) ? rand_word() : 0;
            b = ($urandom_range(1) != 0) ? rand_word() : 0;
            if ($urandom_range(3) == 0)
                a = 0;
            c = ($urandom_range(1) != 0) ? rand_word() : rand_span(50);
        end
        else
        begin
            idx = $urandom_range(45, 20);
            a   = ($urandom_range(1) != 0) ? fib[idx] : -fib[idx];
            b   = ($urandom_range(1) != 0) ? fib[idx + 1] : -fib[idx + 1];
            if ($urandom_range(1) != 0)
            begin
                g = a;
                a = b;
                b = g;
            end
            c = rand_word();
        end
        return make_item(a, b, c);
    endfunction

    // Offers one beat to the block and waits until it is taken. Valid is lowered only for an
    // idle gap, so a valid that stays high across back-to-back beats gets one assignment per
    // time step.
    task automatic offer_item(input item_t it, input bit known, input result_t want);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_solutions.push_back(known ? want : solve_item(it));
    endtask

    // Result side: checks every accepted beat against the oldest expectation and drives the
    // stall line. A requested hold-off is counted down here in cycles.
    initial
    begin : result_side
        int unsigned hold_left;
        bit          hold_done;
        result_t     want;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_solutions.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got x=%0d y=%0d st=%0d ov=%0d",
                             $time, result.sol_x, result.sol_y, result.status, result.overflow);
                    error_count++;
                end
                else
                begin
                    want = pending_solutions.pop_front();
                    if (result.sol_x !== want.sol_x)
                    begin
                        $display("%0t: sol_x expected %0d got %0d", $time, want.sol_x,
                                 result.sol_x);
                        error_count++;
                    end
                    if (result.sol_y !== want.sol_y)
                    begin
                        $display("%0t: sol_y expected %0d got %0d", $time, want.sol_y,
                                 result.sol_y);
                        error_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status,
                                 result.status);
                        error_count++;
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %0d got %0d", $time, want.overflow,
                                 result.overflow);
                        error_count++;
                    end
                end
            end
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    // The run ends here as a failure if it has not finished in time.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t    dir_rows[$];
        dir_row_t    row;
        result_t     none;
        int          i;
        int          set;

        none = '0;
        fib[0] = 0;
        fib[1] = 1;
        for (i = 2; i < 48; i++)
            fib[i] = fib[i - 1] + fib[i - 2];

        // Directed table. Both-zero coefficients, missing solutions and a single nonzero
        // coefficient have results that are plain to see. The rest go to the predictor.
        row = '{make_item(0, 0, 0), 1'b1, make_result(0, 0, ST_ZERO, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(0, 0, 2147483647), 1'b1, make_result(0, 0, ST_ZERO, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(0, 0, -2147483647), 1'b1, make_result(0, 0, ST_ZERO, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(1, 0, 7), 1'b1, make_result(7, 0, ST_SOLVED, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(0, 1, -7), 1'b1, make_result(0, -7, ST_SOLVED, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(-1, 0, 7), 1'b1, make_result(-7, 0, ST_SOLVED, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(0, -1, 7), 1'b1, make_result(0, -7, ST_SOLVED, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(2, 4, 3), 1'b1, make_result(0, 0, ST_NO_SOL, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(2147483647, 2147483647, 1), 1'b1, make_result(0, 0, ST_NO_SOL, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(-2147483647, -2147483647, -2147483646), 1'b1,
                make_result(0, 0, ST_NO_SOL, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(2147483647, 0, 2147483647), 1'b1, make_result(1, 0, ST_SOLVED, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(-2147483647, 0, 2147483647), 1'b1,
                make_result(-1, 0, ST_SOLVED, 1'b0)};
        dir_rows.push_back(row);
        row = '{make_item(3, 5, 2147483647), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(2, 3, -2147483647), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(-2147483647, 2147483646, 1), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(1836311903, 1134903170, 1), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(-1836311903, 1134903170, -2147483647), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(2147483647, 2147483647, -2147483647), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(6, 10, 8), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(-12, 18, -30), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(1, 1, 0), 1'b0, none};
        dir_rows.push_back(row);
        row = '{make_item(7, -3, 2147483647), 1'b0, none};
        dir_rows.push_back(row);

        // Hold reset at the start and release it on a rising edge.
        repeat (11) @(posedge clk);
        rst_n     <= 1'b1;
        send_idle <= 25;
        recv_idle <= 59;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want);

        // Three sets of random items: sender idles less than receiver, then the reverse, then
        // no idling at all. The last set starts with a long output hold-off, during which the
        // sender keeps offering beats until the block fills up and stalls its input.
        for (set = 0; set < 3; set++)
        begin
            if (set == 1)
            begin
                send_idle <= 59;
                recv_idle <= 25;
            end
            else if (set == 2)
            begin
                send_idle  <= 0;
                recv_idle  <= 0;
                hold_armed <= 1'b1;
            end
            for (i = 0; i < ITEMS_PER_SET; i++)
                offer_item(random_item(), 1'b0, none);
        end
        item_valid <= 1'b0;

        while (pending_solutions.size() != 0)
            @(posedge clk);
        // Allow for a stray beat to show up after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
